/* rtl/ffua_pkg.sv */
// shared types and constants of the first-fit unit allocator
package ffua_pkg;

    // request codes
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // result status codes
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    // saturation value of the 8-bit result counters
    localparam logic [7:0] CNT_MAX = 8'hFF;

    // reset value of the fragment limit register
    localparam logic [7:0] LIMIT_RESET = 8'd2;

    // apb byte address of the fragment limit register
    localparam logic [1:0] REG_LIMIT_ADDR = 2'd0;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] process_id;
        logic [7:0]  units;
    } t_in;

    typedef struct packed {
        logic       status;
        logic [7:0] traversed;
        logic [7:0] fragments;
    } t_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FINISH
    } t_state;

endpackage

/* rtl/first_fit_unit_allocator_top.sv */
// first-fit contiguous unit allocator, top level
// request channel (i_in_valid / o_in_stall / i_in) takes one beat: allocate a
// contiguous run of units for an owner, free every unit of an owner, or count
// free runs no longer than the fragment limit; one result beat per request
// leaves in request order on (o_out_valid / i_out_stall / o_out)
// the apb port holds one register at byte address 0, the fragment limit
// one request at a time: o_in_stall is high from accept until the result is
// loaded into the output register; the next request can be taken in the cycle after
// a query or a free walks the table one unit per cycle through the single
// read port of the table memory
// an allocate stops after the first fitting run, then writes the owner into
// each unit of the run, one table write a cycle
// reset: a clearing pass marks every unit free; requests are stalled
// meanwhile, apb writes are taken as ever
// stall: the output register holds its beat while i_out_stall is high; the
// next request is accepted meanwhile and its result waits until the register
// is free
module first_fit_unit_allocator_top #(
    parameter int NUM_UNITS = 128,
    parameter int ID_BITS   = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // request channel
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ffua_pkg::t_in i_in,
    // result channel
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ffua_pkg::t_out o_out,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(NUM_UNITS);       // table address bits
    localparam int CW = $clog2(NUM_UNITS + 1);   // counts up to NUM_UNITS
    localparam int MW = (CW > 8) ? CW : 8;       // common compare width
    localparam int DW = ID_BITS + 1;             // table word: free bit + owner

    // table memory: bit ID_BITS is the free flag, low bits the owner
    logic [DW-1:0] r_mem [NUM_UNITS];
    logic [DW-1:0] r_rdata;

    ffua_pkg::t_state r_state, n_state;

    // request registers
    logic [1:0]         r_act;
    logic [ID_BITS-1:0] r_pid;
    logic [7:0]         r_need;

    // scan registers
    logic [CW-1:0] r_rd;          // next read address, stops at NUM_UNITS
    logic          r_dv;          // r_rdata holds the unit at r_pos
    logic [AW-1:0] r_pos;         // unit being examined, also clear address
    logic [CW-1:0] r_run_len;     // length of the current free run, 0 outside
    logic [AW-1:0] r_run_start;
    logic [7:0]    r_visits;
    logic [7:0]    r_count;
    logic          r_any;

    // mark registers
    logic [AW-1:0] r_mk;
    logic [7:0]    r_left;

    // result being built and the output register
    logic       r_status;
    logic [7:0] r_trav;
    logic [7:0] r_frag;
    logic       r_out_valid;
    ffua_pkg::t_out r_out;

    logic [7:0] r_limit;

    // memory port controls
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // scan decode
    logic          accept;
    logic          proc;
    logic          unit_free;
    logic          own_match;
    logic          last;
    logic [CW-1:0] new_len;
    logic          fit;
    logic          alloc_hit;
    logic          free_hit;
    logic [7:0]    vis_inc;
    logic [7:0]    vis_next;
    logic [7:0]    cnt_inc;
    logic [7:0]    cnt_next;
    logic          run_counts;
    logic          load_out;

    assign accept    = i_in_valid && !o_in_stall;
    assign proc      = (r_state == ffua_pkg::ST_SCAN) && r_dv;
    assign unit_free = r_rdata[ID_BITS];
    assign own_match = (r_rdata[ID_BITS-1:0] == r_pid);
    assign last      = (r_pos == AW'(NUM_UNITS - 1));
    assign new_len   = r_run_len + CW'(1);
    assign fit       = (MW'(new_len) >= MW'(r_need));
    assign alloc_hit = proc && (r_act == ffua_pkg::ACT_ALLOC) && unit_free && fit;
    assign free_hit  = proc && (r_act == ffua_pkg::ACT_FREE) && !unit_free && own_match;
    assign load_out  = (r_state == ffua_pkg::ST_FINISH) && (!r_out_valid || !i_out_stall);

    // saturating node count: an occupied unit or the head of a free run
    assign vis_inc  = (r_visits == ffua_pkg::CNT_MAX) ? r_visits : r_visits + 8'd1;
    assign vis_next = (!unit_free || (r_run_len == '0)) ? vis_inc : r_visits;

    // a free run closes at an occupied unit, or at the table end while free
    always_comb begin
        run_counts = 1'b0;
        if (unit_free) begin
            run_counts = last && (MW'(new_len) <= MW'(r_limit));
        end else begin
            run_counts = (r_run_len != '0) && (MW'(r_run_len) <= MW'(r_limit));
        end
    end
    assign cnt_inc  = (r_count == ffua_pkg::CNT_MAX) ? r_count : r_count + 8'd1;
    assign cnt_next = run_counts ? cnt_inc : r_count;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffua_pkg::ST_CLEAR: begin
                if (last) n_state = ffua_pkg::ST_IDLE;
            end
            ffua_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in.action == ffua_pkg::ACT_NONE) ?
                              ffua_pkg::ST_FINISH : ffua_pkg::ST_SCAN;
                end
            end
            ffua_pkg::ST_SCAN: begin
                if (alloc_hit) begin
                    n_state = (r_need == 8'd0) ? ffua_pkg::ST_FINISH : ffua_pkg::ST_MARK;
                end else if (proc && last) begin
                    n_state = ffua_pkg::ST_FINISH;
                end
            end
            ffua_pkg::ST_MARK: begin
                if (r_left == 8'd1) n_state = ffua_pkg::ST_FINISH;
            end
            ffua_pkg::ST_FINISH: begin
                if (load_out) n_state = ffua_pkg::ST_IDLE;
            end
            default: n_state = ffua_pkg::ST_CLEAR;
        endcase
    end

    // state outputs: memory port and request stall
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = r_pos;
        mem_wdata  = {1'b1, {ID_BITS{1'b0}}};
        mem_re     = 1'b0;
        mem_raddr  = r_rd[AW-1:0];
        o_in_stall = 1'b1;
        unique case (r_state)
            ffua_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ffua_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ffua_pkg::ST_SCAN: begin
                mem_re = (r_rd < CW'(NUM_UNITS));
                mem_we = free_hit;
            end
            ffua_pkg::ST_MARK: begin
                mem_we    = 1'b1;
                mem_waddr = r_mk;
                mem_wdata = {1'b0, r_pid};
            end
            ffua_pkg::ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // table memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffua_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture and scan datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_dv  <= 1'b0;
            r_rd  <= '0;
        end else begin
            if (r_state == ffua_pkg::ST_CLEAR) begin
                r_pos <= r_pos + AW'(1);
            end
            if (accept) begin
                r_act     <= i_in.action;
                r_pid     <= ID_BITS'(i_in.process_id);
                r_need    <= i_in.units;
                r_rd      <= '0;
                r_dv      <= 1'b0;
                r_pos     <= '0;
                r_run_len <= '0;
                r_visits  <= '0;
                r_count   <= '0;
                r_any     <= 1'b0;
                r_status  <= ffua_pkg::STAT_FAIL;
                r_trav    <= '0;
                r_frag    <= '0;
            end
            if (r_state == ffua_pkg::ST_SCAN) begin
                r_dv <= mem_re;
                if (mem_re) r_rd <= r_rd + CW'(1);
            end
            if (proc) begin
                r_pos <= r_pos + AW'(1);
                unique case (r_act)
                    ffua_pkg::ACT_ALLOC: begin
                        r_visits <= vis_next;
                        if (unit_free) begin
                            if (r_run_len == '0) r_run_start <= r_pos;
                            r_run_len <= new_len;
                        end else begin
                            r_run_len <= '0;
                        end
                        if (alloc_hit) begin
                            r_status <= ffua_pkg::STAT_OK;
                            r_trav   <= vis_next;
                            r_mk     <= (r_run_len == '0) ? r_pos : r_run_start;
                            r_left   <= r_need;
                        end
                    end
                    ffua_pkg::ACT_FREE: begin
                        if (free_hit) r_any <= 1'b1;
                        if (last) begin
                            r_status <= (r_any || free_hit) ?
                                        ffua_pkg::STAT_OK : ffua_pkg::STAT_FAIL;
                        end
                    end
                    ffua_pkg::ACT_QUERY: begin
                        r_count   <= cnt_next;
                        r_run_len <= unit_free ? new_len : '0;
                        if (last) begin
                            r_status <= ffua_pkg::STAT_OK;
                            r_frag   <= cnt_next;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == ffua_pkg::ST_MARK) begin
                r_mk   <= r_mk + AW'(1);
                r_left <= r_left - 8'd1;
            end
        end
    end

    // output register: holds its beat while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.status    <= r_status;
            r_out.traversed <= r_trav;
            r_out.fragments <= r_frag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // fragment limit register, the only register of the apb port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ffua_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite) begin
            r_limit <= pwdata[7:0];
        end
    end

    assign prdata = {24'd0, r_limit};
    assign pready = 1'b1;

endmodule

/* rtl/ffua_checker.sv */
// port-level checker of the first-fit unit allocator and its bind
module ffua_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input ffua_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input ffua_pkg::t_out o_out
);

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result beat dropped or changed");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while busy");

    // a failed result carries no counts
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ffua_pkg::STAT_FAIL) |->
        (o_out.traversed == 8'd0) && (o_out.fragments == 8'd0))
        else $error("failed result with nonzero count");

    // only one of the two counts applies to a request
    a_one_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.traversed == 8'd0) || (o_out.fragments == 8'd0))
        else $error("both counts nonzero");

endmodule

bind first_fit_unit_allocator_top ffua_checker u_ffua_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

/* sim/ffua_result_checker.sv */
// result checker for the unit allocator: watches both channels and the apb port, predicts and compares
`timescale 1ns / 1ps
module ffua_result_checker #(
    parameter int NUM_UNITS = 128,
    parameter int ID_BITS   = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  ffua_pkg::t_in   i_in_beat,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  ffua_pkg::t_out  i_out_beat,
    input  logic            i_psel,
    input  logic            i_penable,
    input  logic            i_pwrite,
    input  logic [1:0]      i_paddr,
    input  logic [31:0]     i_pwdata,
    input  logic            i_pready,
    output int              o_errors,
    output int              o_outstanding
);

    logic               unit_taken [NUM_UNITS];
    logic [ID_BITS-1:0] unit_pid   [NUM_UNITS];
    logic [7:0]         frag_limit;
    ffua_pkg::t_out     expected_results [$];
    int                 n_mismatch = 0;

    assign o_errors = n_mismatch;

    // applies one request to the shadow table and returns its result beat
    function automatic ffua_pkg::t_out table_outcome(input ffua_pkg::t_in req);
        ffua_pkg::t_out     res;
        int                 pos;
        int                 start;
        int                 visits;
        int                 runs;
        int                 k;
        logic [ID_BITS-1:0] pid;
        logic               hit;
        res.status    = ffua_pkg::STAT_FAIL;
        res.traversed = '0;
        res.fragments = '0;
        pid           = ID_BITS'(req.process_id);
        pos           = 0;
        visits        = 0;
        runs          = 0;
        hit           = 1'b0;
        unique case (req.action)
            ffua_pkg::ACT_ALLOC: begin
                while (pos < NUM_UNITS && !hit) begin
                    visits++;
                    if (!unit_taken[pos]) begin
                        start = pos;
                        while (pos < NUM_UNITS && !unit_taken[pos]) pos++;
                        if (pos - start >= int'(req.units)) begin
                            for (k = 0; k < int'(req.units); k++) begin
                                unit_taken[start + k] = 1'b1;
                                unit_pid[start + k]   = pid;
                            end
                            hit           = 1'b1;
                            res.status    = ffua_pkg::STAT_OK;
                            res.traversed = (visits > 255) ? ffua_pkg::CNT_MAX : 8'(visits);
                        end
                    end else begin
                        pos++;
                    end
                end
            end
            ffua_pkg::ACT_FREE: begin
                for (k = 0; k < NUM_UNITS; k++) begin
                    if (unit_taken[k] && unit_pid[k] == pid) begin
                        unit_taken[k] = 1'b0;
                        hit           = 1'b1;
                    end
                end
                res.status = hit ? ffua_pkg::STAT_OK : ffua_pkg::STAT_FAIL;
            end
            ffua_pkg::ACT_QUERY: begin
                while (pos < NUM_UNITS) begin
                    if (!unit_taken[pos]) begin
                        start = pos;
                        while (pos < NUM_UNITS && !unit_taken[pos]) pos++;
                        if (pos - start <= int'(frag_limit)) runs++;
                    end else begin
                        pos++;
                    end
                end
                res.status    = ffua_pkg::STAT_OK;
                res.fragments = (runs > 255) ? ffua_pkg::CNT_MAX : 8'(runs);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic report_field(input string field, input int exp_val, input int got_val);
        n_mismatch++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, got_val);
    endtask

    always @(posedge i_clk) begin
        ffua_pkg::t_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_UNITS; i++) begin
                unit_taken[i] = 1'b0;
                unit_pid[i]   = '0;
            end
            frag_limit = ffua_pkg::LIMIT_RESET;
            expected_results.delete();
            o_outstanding <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr == ffua_pkg::REG_LIMIT_ADDR)
                frag_limit = i_pwdata[7:0];
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(table_outcome(i_in_beat));
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    n_mismatch++;
                    $display("%0t: result beat with nothing expected, got %h", $time, i_out_beat);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_beat.status !== want.status)
                        report_field("status", want.status, i_out_beat.status);
                    if (i_out_beat.traversed !== want.traversed)
                        report_field("traversed", want.traversed, i_out_beat.traversed);
                    if (i_out_beat.fragments !== want.fragments)
                        report_field("fragments", want.fragments, i_out_beat.fragments);
                end
            end
            o_outstanding <= expected_results.size();
        end
    end

endmodule

/* sim/first_fit_unit_allocator_top_tb.sv */
// testbench top for the unit allocator: stimulus, idle profiles, watchdog and verdict
`timescale 1ns / 1ps
module first_fit_unit_allocator_top_tb;

    localparam int NUM_UNITS   = 128;
    localparam int ID_BITS     = 16;
    localparam int STUCK_LIMIT = 5000;   // cycles with no beat before giving up
    localparam int PHASE_ITEMS = 238;
    localparam int N_PIDS      = 12;
    localparam int N_PHASES    = 6;

    logic           i_clk;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           o_in_stall;
    ffua_pkg::t_in  i_in        = '0;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    ffua_pkg::t_out o_out;
    logic           psel        = 1'b0;
    logic           penable     = 1'b0;
    logic           pwrite      = 1'b0;
    logic [1:0]     paddr       = '0;
    logic [31:0]    pwdata      = '0;
    logic [31:0]    prdata;
    logic           pready;

    int send_idle    = 0;   // percent of cycles the request side holds back
    int recv_idle    = 0;   // percent of cycles the result side stalls
    int n_sent       = 0;
    int n_limits     = 0;
    int mismatches;
    int outstanding;
    int stuck_cycles = 0;

    // small set of owners so that frees mostly hit something
    logic [15:0] owner_pool [N_PIDS];

    first_fit_unit_allocator_top #(
        .NUM_UNITS (NUM_UNITS),
        .ID_BITS   (ID_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    ffua_result_checker #(
        .NUM_UNITS (NUM_UNITS),
        .ID_BITS   (ID_BITS)
    ) u_result_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_beat     (i_in),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_beat    (o_out),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_errors      (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle);
    end

    // watchdog: any beat on either channel or an apb access restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable && pready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STUCK_LIMIT);
            $display("[first_fit_unit_allocator_top] ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic ffua_pkg::t_in pack_request(input logic [1:0] action,
                                                   input logic [15:0] pid,
                                                   input logic [7:0] units);
        ffua_pkg::t_in req;
        req.action     = action;
        req.process_id = pid;
        req.units      = units;
        return req;
    endfunction

    // mostly allocate/free traffic on pooled owners with small sizes,
    // some queries, some unknown actions and oversize or zero requests
    function automatic ffua_pkg::t_in random_request();
        ffua_pkg::t_in req;
        int            pick;
        int            size_pick;
        pick      = $urandom_range(99);
        size_pick = $urandom_range(99);
        req.process_id = ($urandom_range(9) == 0) ? 16'($urandom)
                                                  : owner_pool[$urandom_range(N_PIDS - 1)];
        if (size_pick < 70)
            req.units = 8'($urandom_range(8, 1));
        else if (size_pick < 90)
            req.units = 8'($urandom_range(40, 9));
        else if (size_pick < 97)
            req.units = 8'($urandom_range(128, 41));
        else
            req.units = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 129));
        if (pick < 55)
            req.action = ffua_pkg::ACT_ALLOC;
        else if (pick < 80)
            req.action = ffua_pkg::ACT_FREE;
        else if (pick < 95)
            req.action = ffua_pkg::ACT_QUERY;
        else
            req.action = ffua_pkg::ACT_NONE;
        return req;
    endfunction

    // hold off at random, then present the beat until it is taken;
    // valid stays high on return so back-to-back beats need no extra drive
    task automatic issue(input ffua_pkg::t_in req);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
    endtask

    // setup then access phase; upper data bits are noise the register drops
    task automatic write_limit(input logic [7:0] limit);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ffua_pkg::REG_LIMIT_ADDR;
        pwdata  <= {24'($urandom), limit};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_limits++;
    endtask

    // wait for every result, then give a full table walk plus owner writes of slack
    task automatic wait_drained();
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (NUM_UNITS * 2 + 8) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] limit;
        for (int i = 0; i < N_PIDS; i++) owner_pool[i] = 16'($urandom);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part runs with the reset limit of 2
        send_idle = 17;
        recv_idle = 73;
        issue(pack_request(ffua_pkg::ACT_QUERY, 16'h0000, 8'd0));   // empty table: one long run
        issue(pack_request(ffua_pkg::ACT_NONE,  16'hFFFF, 8'hFF));  // unknown action
        issue(pack_request(ffua_pkg::ACT_FREE,  16'h1234, 8'd1));   // owner holds nothing
        issue(pack_request(ffua_pkg::ACT_ALLOC, 16'hFFFF, 8'd128)); // whole table at once
        issue(pack_request(ffua_pkg::ACT_ALLOC, 16'h0001, 8'd0));   // zero units on a full table
        issue(pack_request(ffua_pkg::ACT_ALLOC, 16'h0001, 8'd1));   // no room
        issue(pack_request(ffua_pkg::ACT_QUERY, 16'h0000, 8'd0));   // no free runs
        issue(pack_request(ffua_pkg::ACT_FREE,  16'hFFFF, 8'd0));
        issue(pack_request(ffua_pkg::ACT_ALLOC, 16'h0000, 8'd0));   // zero units, empty table
        issue(pack_request(ffua_pkg::ACT_ALLOC, 16'h0000, 8'd129)); // longer than the table
        issue(pack_request(ffua_pkg::ACT_ALLOC, 16'h0000, 8'd255));
        issue(pack_request(ffua_pkg::ACT_ALLOC, 16'h0000, 8'd1));
        issue(pack_request(ffua_pkg::ACT_ALLOC, 16'hA5A5, 8'd2));
        issue(pack_request(ffua_pkg::ACT_ALLOC, 16'h5A5A, 8'd1));
        issue(pack_request(ffua_pkg::ACT_ALLOC, 16'hA5A5, 8'd3));
        issue(pack_request(ffua_pkg::ACT_FREE,  16'h0000, 8'd0));   // one-unit hole at the front
        issue(pack_request(ffua_pkg::ACT_QUERY, 16'h0000, 8'd0));
        issue(pack_request(ffua_pkg::ACT_ALLOC, 16'h0F0F, 8'd2));   // skips the hole
        issue(pack_request(ffua_pkg::ACT_FREE,  16'hA5A5, 8'd0));   // owner with split units
        issue(pack_request(ffua_pkg::ACT_QUERY, 16'h0000, 8'd0));
        issue(pack_request(ffua_pkg::ACT_ALLOC, 16'hF0F0, 8'd1));
        issue(pack_request(ffua_pkg::ACT_ALLOC, 16'h8001, 8'd1));
        issue(pack_request(ffua_pkg::ACT_QUERY, 16'h0000, 8'd0));
        issue(pack_request(ffua_pkg::ACT_NONE,  16'h0000, 8'd0));
        i_in_valid <= 1'b0;

        // random phases: each sets the idle profile and writes the fragment limit,
        // covering the limit extremes including zero and the full 8-bit range
        for (int phase = 0; phase < N_PHASES; phase++) begin
            wait_drained();
            unique case (phase)
                0: begin send_idle = 17; recv_idle = 73; limit = 8'd1;   end
                1: begin send_idle = 17; recv_idle = 73; limit = 8'd128; end
                2: begin send_idle = 73; recv_idle = 17; limit = 8'd255; end
                3: begin send_idle = 73; recv_idle = 17; limit = 8'd0;   end
                4: begin send_idle = 0;  recv_idle = 0;  limit = 8'd7;   end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                    limit     = 8'($urandom_range(128, 1));
                end
            endcase
            write_limit(limit);
            for (int n = 0; n < PHASE_ITEMS; n++) issue(random_request());
            i_in_valid <= 1'b0;
        end

        wait_drained();
        $display("sent %0d requests (allocate, free, fragment query, unknown) over %0d limit writes",
                 n_sent, n_limits);
        $display("idle profiles: sender-heavy stall, receiver-heavy stall, and none");
        if (mismatches == 0)
            $display("[first_fit_unit_allocator_top] OK");
        else
            $display("[first_fit_unit_allocator_top] ERROR");
        $finish;
    end

endmodule
